[rtl/differential_drive_odometry_top_defines.svh]
// ---------------------------------------------------------------------------
// Odometry assertion macros
// Shared property shorthands, sampled on clk and muted while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define DDO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ddo_pkg.sv]
// ---------------------------------------------------------------------------
// Odometry package
// Request types, register indexes, fixed constants, state codes, atan table.
// ---------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_MPT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IWB = 2'd1;

  localparam logic [31:0] MPT_RESET  = 32'd759289;
  localparam logic [31:0] IWB_RESET  = 32'd43018502;
  localparam logic [31:0] INV_TWO_PI = 32'd683565276;   // 1/(2pi), Q0.32
  localparam logic signed [33:0] CORDIC_ONE = 34'sd652032874;
  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam logic [40:0] VEL_CLAMP = 41'h100_0000_0000;

  localparam int MUL_STEPS = 32;   // radix-4 over a 64-bit operand
  localparam int DIV_STEPS = 60;   // one quotient bit per cycle
  localparam int DIVD_W    = 60;
  localparam int DIVS_W    = 24;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic               counts_valid;
    logic [23:0]        elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] turn_rate;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIFF, ST_MS, ST_K, ST_FR, ST_DB, ST_CINIT, ST_CORD,
    ST_MX, ST_MY, ST_MT, ST_UPD, ST_VM, ST_VD, ST_VSAT, ST_OUT
  } state_t;

  // atan(2^-i) as a binary angle
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ddo_ifs.sv]
// ---------------------------------------------------------------------------
// Odometry channel interfaces
// Valid/ready channels for sample requests and pose results.
// ---------------------------------------------------------------------------
`default_nettype none

interface ddo_in_if;
  import ddo_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ddo_out_if;
  import ddo_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/ddo_mul.sv]
// ---------------------------------------------------------------------------
// Serial multiplier
// Unsigned 64x64 product, two multiplier bits retired per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ddo_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [63:0]         a,
  input  logic [63:0]         b,
  output ddo_pkg::unit_stat_t stat,
  output logic [127:0]        p
);
  import ddo_pkg::*;

  localparam int CW = $clog2(MUL_STEPS);

  logic [63:0]  a_r;
  logic [65:0]  a3_r;
  logic [127:0] p_r;
  logic [CW-1:0] cnt_r;
  logic         busy_r, done_r;
  logic [65:0]  addend, sum;

  always_comb begin
    case (p_r[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, a_r};
      2'd2:    addend = {1'b0, a_r, 1'b0};
      default: addend = a3_r;
    endcase
    sum = {2'b00, p_r[127:64]} + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      a3_r <= {2'b00, a} + {1'b0, a, 1'b0};
      p_r  <= {64'd0, b};
    end else if (busy_r) begin
      p_r <= {sum, p_r[63:2]};
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign p    = p_r;

endmodule

`default_nettype wire

[rtl/ddo_div.sv]
// ---------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ddo_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ddo_pkg::DIVD_W-1:0]  dividend,
  input  logic [ddo_pkg::DIVS_W-1:0]  divisor,
  output ddo_pkg::unit_stat_t         stat,
  output logic [ddo_pkg::DIVD_W-1:0]  quot
);
  import ddo_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  logic [DIVD_W-1:0] q_r;
  logic [DIVS_W-1:0] d_r, rem_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [DIVS_W:0]   shifted;
  logic [DIVS_W+1:0] diff;
  logic              ge;

  always_comb begin
    shifted = {rem_r, q_r[DIVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, d_r};
    ge      = !diff[DIVS_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
      q_r   <= {q_r[DIVD_W-2:0], ge};
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign quot = q_r;

endmodule

`default_nettype wire

[rtl/differential_drive_odometry_top.sv]
// ---------------------------------------------------------------------------
// Differential-drive wheel odometry
// Encoder samples in, integrated pose and velocities out, fixed point.
// ---------------------------------------------------------------------------
// Sequence: from sample request to result valid the block makes ten passes
//   of the serial multiplier and three divider passes, runs one CORDIC step
//   per cycle and steps through the states DIFF, CINIT, UPD and VSAT;
//   with zero elapsed time the divider is skipped.
// Requests: a new request is taken once the previous result has been
//   handed off, so one sample is in work at a time.
// Reset (rst_n low, synchronous): pose and stored counts go to zero and
//   the registers to their defaults; no clearing pass is needed.
`default_nettype none

module differential_drive_odometry_top #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0]   cfg_data,
  ddo_in_if.sink                           in_ch,
  ddo_out_if.source                        out_ch
);
  import ddo_pkg::*;

  localparam int IW = $clog2(CORDIC_STEPS);

  // ---- configuration registers ----
  logic [31:0] mpt_r, iwb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r <= MPT_RESET;
      iwb_r <= IWB_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MPT) mpt_r <= cfg_data;
      if (cfg_index == CFG_IWB) iwb_r <= cfg_data;
    end
  end

  // ---- sequencer ----
  state_t state_r, state_nxt;
  logic   go_r;
  logic   mul_start, div_start;
  logic [63:0] mul_a, mul_b;
  logic [127:0] mul_p;
  logic [DIVD_W-1:0] div_q;
  unit_stat_t mul_st, div_st;

  // ---- datapath registers ----
  in_item_t    req_r;
  logic [31:0] prev_l_r, prev_r_r, acc_x_r, acc_y_r, acc_h_r;
  logic [32:0] mag_sum_r, mag_d_r;
  logic        neg_sum_r, neg_d_r;
  logic [62:0] mag_s_r;
  logic        neg_s_r;
  logic [63:0] k_r, frac_r;
  logic [31:0] dbam_r;
  logic        flip_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic [IW-1:0] i_r;
  logic [63:0] mx_r, my_r, mth_r;
  logic        nx_r, ny_r, nt_r;
  logic [1:0]  vsel_r;
  logic signed [31:0] vx_r, vy_r, vt_r;

  wire in_acc  = in_ch.valid && in_ch.ready;
  wire out_acc = out_ch.valid && out_ch.ready;
  wire cord_last = (i_r == IW'(CORDIC_STEPS - 1));
  wire no_time   = (req_r.elapsed_us == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MS;
      ST_MS:    if (mul_st.done) state_nxt = ST_K;
      ST_K:     if (mul_st.done) state_nxt = ST_FR;
      ST_FR:    if (mul_st.done) state_nxt = ST_DB;
      ST_DB:    if (mul_st.done) state_nxt = ST_CINIT;
      ST_CINIT: state_nxt = ST_CORD;
      ST_CORD:  if (cord_last) state_nxt = ST_MX;
      ST_MX:    if (mul_st.done) state_nxt = ST_MY;
      ST_MY:    if (mul_st.done) state_nxt = ST_MT;
      ST_MT:    if (mul_st.done) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_VM;
      ST_VM:    if (mul_st.done) state_nxt = no_time ? ST_VSAT : ST_VD;
      ST_VD:    if (div_st.done) state_nxt = ST_VSAT;
      ST_VSAT:  state_nxt = (vsel_r == 2'd2) ? ST_OUT : ST_VM;
      ST_OUT:   if (out_acc) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // velocity operand select: x, y, then turn
  logic [63:0] vmag;
  logic        vneg;
  logic [40:0] vclamp;

  always_comb begin
    case (vsel_r)
      2'd0:    begin vmag = mx_r;  vneg = nx_r; end
      2'd1:    begin vmag = my_r;  vneg = ny_r; end
      default: begin vmag = mth_r; vneg = nt_r; end
    endcase
    vclamp = (vmag > {23'd0, VEL_CLAMP}) ? VEL_CLAMP : vmag[40:0];
  end

  // signed cos/sin after undoing the half-turn fold
  logic signed [33:0] cval, sval;
  logic [31:0] cmag, smag;
  logic        cneg, sneg;

  always_comb begin
    cval = flip_r ? -x_r : x_r;
    sval = flip_r ? -y_r : y_r;
    cneg = cval[33];
    sneg = sval[33];
    cmag = cneg ? 32'(-cval) : cval[31:0];
    smag = sneg ? 32'(-sval) : sval[31:0];
  end

  // unit launches and channel controls
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_MS: begin
        mul_a = {31'd0, mag_sum_r};
        mul_b = {32'd0, mpt_r};
      end
      ST_K: begin
        mul_a = {32'd0, mpt_r};
        mul_b = {32'd0, iwb_r};
      end
      ST_FR: begin
        mul_a = k_r;
        mul_b = {32'd0, INV_TWO_PI};
      end
      ST_DB: begin
        mul_a = frac_r;
        mul_b = {31'd0, mag_d_r};
      end
      ST_MX: begin
        mul_a = {1'b0, mag_s_r};
        mul_b = {32'd0, cmag};
      end
      ST_MY: begin
        mul_a = {1'b0, mag_s_r};
        mul_b = {32'd0, smag};
      end
      ST_MT: begin
        mul_a = k_r;
        mul_b = {31'd0, mag_d_r};
      end
      ST_VM: begin
        mul_a = {23'd0, vclamp};
        mul_b = {44'd0, US_PER_S};
      end
      default: ;
    endcase
    unique case (state_r)
      ST_MS, ST_K, ST_FR, ST_DB, ST_MX, ST_MY, ST_MT, ST_VM: mul_start = !go_r;
      ST_VD:   div_start = !go_r;
      default: ;
    endcase
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.data  = '{pos_x: acc_x_r, pos_y: acc_y_r, heading: acc_h_r,
                          vel_x: vx_r, vel_y: vy_r, turn_rate: vt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mul_start || div_start)       go_r <= 1'b1;
      else if (mul_st.done || div_st.done) go_r <= 1'b0;
    end
  end

  // ---- shared arithmetic units ----
  ddo_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mul_st),
    .p     (mul_p)
  );

  ddo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_p[DIVD_W-1:0]),
    .divisor  (req_r.elapsed_us),
    .stat     (div_st),
    .quot     (div_q)
  );

  // ---- tick differences (wrap in 32 bits) ----
  logic [31:0] cur_l, cur_r, dl32, dr32;
  logic signed [33:0] sum34, dif34;

  always_comb begin
    cur_l = req_r.counts_valid ? req_r.left_count  : prev_l_r;
    cur_r = req_r.counts_valid ? req_r.right_count : prev_r_r;
    dl32  = cur_l - prev_l_r;
    dr32  = cur_r - prev_r_r;
    sum34 = $signed({{2{dl32[31]}}, dl32}) + $signed({{2{dr32[31]}}, dr32});
    dif34 = $signed({{2{dr32[31]}}, dr32}) - $signed({{2{dl32[31]}}, dl32});
  end

  // ---- heading change, mid-step angle ----
  logic [63:0] dbam64, dbam_rnd;
  logic [31:0] half_d, mid_ang, rot_ang;
  logic        flip_nxt;

  always_comb begin
    dbam64   = neg_d_r ? -mul_p[63:0] : mul_p[63:0];
    dbam_rnd = dbam64 + 64'h0000_0000_8000_0000;
    half_d   = {dbam_r[31], dbam_r[31:1]};
    mid_ang  = acc_h_r + half_d;
    flip_nxt = (mid_ang[31:30] == 2'd1) || (mid_ang[31:30] == 2'd2);
    rot_ang  = flip_nxt ? mid_ang + 32'h8000_0000 : mid_ang;
  end

  // ---- CORDIC step ----
  logic signed [33:0] xs, ys, at;

  always_comb begin
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = $signed({2'b00, atan_bam(5'(i_r))});
  end

  // ---- saturation of a velocity quotient ----
  logic [DIVD_W-1:0] vq;
  logic [31:0]       vq32, vres;

  always_comb begin
    vq = no_time ? '0 : div_q;
    if (!vneg && vq > DIVD_W'(32'h7FFF_FFFF))      vq32 = 32'h7FFF_FFFF;
    else if (vneg && vq > DIVD_W'(32'h8000_0000))  vq32 = 32'h8000_0000;
    else                                           vq32 = vq[31:0];
    vres = vneg ? -vq32 : vq32;
  end

  // ---- state that reset clears ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_l_r <= '0;
      prev_r_r <= '0;
      acc_x_r  <= '0;
      acc_y_r  <= '0;
      acc_h_r  <= '0;
    end else begin
      if (state_r == ST_DIFF) begin
        prev_l_r <= cur_l;
        prev_r_r <= cur_r;
      end
      if (state_r == ST_UPD) begin
        acc_x_r <= acc_x_r + (nx_r ? -mx_r[31:0] : mx_r[31:0]);
        acc_y_r <= acc_y_r + (ny_r ? -my_r[31:0] : my_r[31:0]);
        acc_h_r <= acc_h_r + dbam_r;
      end
    end
  end

  // ---- working registers ----
  always_ff @(posedge clk) begin
    if (in_acc) req_r <= in_ch.data;
    unique case (state_r)
      ST_DIFF: begin
        neg_sum_r <= sum34[33];
        mag_sum_r <= sum34[33] ? 33'(-sum34) : sum34[32:0];
        neg_d_r   <= dif34[33];
        mag_d_r   <= dif34[33] ? 33'(-dif34) : dif34[32:0];
      end
      ST_MS: if (mul_st.done) begin
        mag_s_r <= mul_p[63:1];
        neg_s_r <= neg_sum_r && (mul_p[63:1] != '0);
      end
      ST_K:  if (mul_st.done) k_r <= mul_p[63:0];
      ST_FR: if (mul_st.done) frac_r <= mul_p[87:24];
      ST_DB: if (mul_st.done) dbam_r <= dbam_rnd[63:32];
      ST_CINIT: begin
        flip_r <= flip_nxt;
        x_r    <= CORDIC_ONE;
        y_r    <= '0;
        z_r    <= $signed({{2{rot_ang[31]}}, rot_ang});
        i_r    <= '0;
      end
      ST_CORD: begin
        if (!z_r[33]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
        i_r <= i_r + 1'b1;
      end
      ST_MX: if (mul_st.done) begin
        mx_r <= mul_p[109:46];
        nx_r <= (neg_s_r != cneg) && (mul_p[109:46] != '0);
      end
      ST_MY: if (mul_st.done) begin
        my_r <= mul_p[109:46];
        ny_r <= (neg_s_r != sneg) && (mul_p[109:46] != '0);
      end
      ST_MT: if (mul_st.done) begin
        mth_r <= mul_p[103:40];
        nt_r  <= neg_d_r && (mul_p[103:40] != '0);
      end
      ST_UPD: vsel_r <= 2'd0;
      ST_VSAT: begin
        case (vsel_r)
          2'd0:    vx_r <= vres;
          2'd1:    vy_r <= vres;
          default: vt_r <= vres;
        endcase
        vsel_r <= vsel_r + 2'd1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/ddo_sva.sv]
// ---------------------------------------------------------------------------
// Odometry port checker
// Handshake and sequencing properties seen on the top-level ports.
// ---------------------------------------------------------------------------
`default_nettype none

`include "differential_drive_odometry_top_defines.svh"

module ddo_sva (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire ddo_pkg::out_item_t out_data
);

  `DDO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
  `DDO_ASSERT_NEXT(a_no_instant, in_valid && in_ready, !out_valid, "result appeared right after request")
  `DDO_ASSERT_NOW(a_busy, out_valid, !in_ready, "request taken while result pending")
  `DDO_ASSERT_NEXT(a_one_result, out_valid && out_ready, !out_valid, "result repeated after handoff")

endmodule

bind differential_drive_odometry_top ddo_sva u_ddo_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire

[dv/ddo_odometry_checker.sv]
// ---------------------------------------------------------------------------
// Odometry pose checker
// Watches the sample and pose channels, integrates its own pose per
// accepted request and compares each pose result field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module ddo_odometry_checker #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data,
  ddo_in_if                              in_mon,
  ddo_out_if                             out_mon,
  output int                             fail_count,
  output int                             pending_count
);
  import ddo_pkg::*;

  logic [31:0] mpt, iwb;
  logic [31:0] last_l, last_r, pose_x, pose_y, pose_h;
  out_item_t   pose_q[$];
  int          mismatches = 0;

  assign fail_count    = mismatches;
  assign pending_count = pose_q.size();

  function automatic logic [31:0] signed_mag(input logic neg, input logic [63:0] mag);
    return neg ? 32'd0 - mag[31:0] : mag[31:0];
  endfunction

  function automatic logic [31:0] speed(input logic neg, input logic [63:0] mag,
                                        input logic [23:0] elapsed);
    logic [63:0] m;
    logic [63:0] q;
    if (elapsed == 24'd0) return 32'd0;
    m = (mag > 64'h100_0000_0000) ? 64'h100_0000_0000 : mag;
    q = (m * 64'd1000000) / {40'd0, elapsed};
    if (!neg && q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    if (neg && q > 64'h8000_0000) q = 64'h8000_0000;
    return signed_mag(neg, q);
  endfunction

  // path length times a trig value, Q16.16 magnitude
  function automatic logic [63:0] path_part(input logic [63:0] path, input longint trig);
    logic [127:0] p;
    logic [63:0]  t;
    t = (trig < 0) ? 64'(-trig) : 64'(trig);
    p = {64'd0, path} * {64'd0, t};
    return p[109:46];
  endfunction

  function automatic out_item_t integrate(input in_item_t s);
    logic [31:0]  cl, cr, dbam, half, mid, ang;
    longint       dl, dr, sum, dif, x, y, z, xs, ys, cs, sn;
    logic         neg_s, neg_d, nx, ny, flip;
    logic [63:0]  mag_s, mag_d, k, frac, db64, mx, my, mth;
    logic [127:0] p;
    out_item_t    r;
    cl = last_l;
    cr = last_r;
    if (s.counts_valid) begin
      cl = s.left_count;
      cr = s.right_count;
    end
    dl = longint'(signed'(cl - last_l));
    dr = longint'(signed'(cr - last_r));
    last_l = cl;
    last_r = cr;
    sum = dl + dr;
    dif = dr - dl;
    neg_s = sum < 0;
    mag_s = neg_s ? 64'(-sum) : 64'(sum);
    mag_s = (mag_s * {32'd0, mpt}) >> 1;
    neg_s = neg_s && mag_s != 0;
    neg_d = dif < 0;
    mag_d = neg_d ? 64'(-dif) : 64'(dif);
    k = {32'd0, mpt} * {32'd0, iwb};
    p = {64'd0, k} * {96'd0, INV_TWO_PI};
    frac = p[87:24];
    db64 = 64'(dif) * frac;
    db64 = db64 + 64'h8000_0000;
    dbam = db64[63:32];
    half = {dbam[31], dbam[31:1]};
    mid = pose_h + half;
    // fold second and third quadrants by half a turn
    flip = (mid[31:30] == 2'b01) || (mid[31:30] == 2'b10);
    ang = flip ? mid + 32'h8000_0000 : mid;
    x = 64'sd652032874;
    y = 0;
    z = longint'(signed'(ang));
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(atan_bam(5'(i)));
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(atan_bam(5'(i)));
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
    mx = path_part(mag_s, cs);
    my = path_part(mag_s, sn);
    nx = (neg_s != (cs < 0)) && mx != 0;
    ny = (neg_s != (sn < 0)) && my != 0;
    p = {64'd0, mag_d} * {64'd0, k};
    mth = p[103:40];
    pose_x = pose_x + signed_mag(nx, mx);
    pose_y = pose_y + signed_mag(ny, my);
    pose_h = pose_h + dbam;
    r.pos_x     = pose_x;
    r.pos_y     = pose_y;
    r.heading   = pose_h;
    r.vel_x     = speed(nx, mx, s.elapsed_us);
    r.vel_y     = speed(ny, my, s.elapsed_us);
    r.turn_rate = speed(neg_d && mth != 0, mth, s.elapsed_us);
    return r;
  endfunction

  function automatic void note(input string f, input logic [31:0] e, input logic [31:0] a);
    mismatches++;
    if (mismatches <= 10)
      $display("pose mismatch %s: expected %h got %h", f, e, a);
  endfunction

  always @(posedge clk) begin
    out_item_t e, a;
    if (!rst_n) begin
      mpt <= MPT_RESET;
      iwb <= IWB_RESET;
      last_l = 0; last_r = 0;
      pose_x = 0; pose_y = 0; pose_h = 0;
      pose_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MPT) mpt <= cfg_data;
        else if (cfg_index == CFG_IWB) iwb <= cfg_data;
      end
      if (out_mon.valid && out_mon.ready) begin
        a = out_mon.data;
        if (pose_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("pose result with none pending: %h", a);
        end else begin
          e = pose_q.pop_front();
          if (e.pos_x !== a.pos_x)         note("pos_x", e.pos_x, a.pos_x);
          if (e.pos_y !== a.pos_y)         note("pos_y", e.pos_y, a.pos_y);
          if (e.heading !== a.heading)     note("heading", e.heading, a.heading);
          if (e.vel_x !== a.vel_x)         note("vel_x", e.vel_x, a.vel_x);
          if (e.vel_y !== a.vel_y)         note("vel_y", e.vel_y, a.vel_y);
          if (e.turn_rate !== a.turn_rate) note("turn_rate", e.turn_rate, a.turn_rate);
        end
      end
      if (in_mon.valid && in_mon.ready)
        pose_q.push_back(integrate(in_mon.data));
    end
  end

endmodule

`default_nettype wire

[dv/tb_differential_drive_odometry_top.sv]
// ---------------------------------------------------------------------------
// Odometry block testbench
// Drives encoder sample requests and register writes, throttles the pose
// channel, and takes the verdict from the pose checker.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_differential_drive_odometry_top;
  import ddo_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count, pending_count;

  ddo_in_if  in_ch ();
  ddo_out_if out_ch ();

  // receiver throttle, percent idle; hold_cycles > 0 means a long hold-off
  int rx_idle = 71;
  int hold_cycles = 0;
  int tx_idle = 9;

  // tb copy of the encoder position so random motion is plausible
  logic [31:0] enc_l = 0, enc_r = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
  end

  differential_drive_odometry_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ddo_odometry_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // pose receiver: random stalls, plus a counted hold-off stretch
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // let the block drain before touching registers; the task waits on the clock
  // first so the checker has logged the last request
  task automatic drain();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // offer one sample request; returns at the edge where it is taken
  task automatic send(input logic signed [31:0] l, input logic signed [31:0] r,
                      input logic fresh, input logic [23:0] us);
    in_item_t s;
    s.left_count   = l;
    s.right_count  = r;
    s.counts_valid = fresh;
    s.elapsed_us   = us;
    if (fresh) begin
      enc_l = l;
      enc_r = r;
    end
    if ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random();
    int          pick;
    logic [31:0] l, r;
    logic [23:0] us;
    pick = $urandom_range(99);
    // mostly steady motion from the last counts, some jumps and stale samples
    if (pick < 70) begin
      l = enc_l + 32'($urandom_range(0, 4000)) - 32'd2000;
      r = enc_r + 32'($urandom_range(0, 4000)) - 32'd2000;
    end else if (pick < 85) begin
      l = $urandom;
      r = $urandom;
    end else begin
      l = enc_l + 32'($urandom_range(0, 200000)) - 32'd100000;
      r = enc_r + 32'($urandom_range(0, 200000)) - 32'd100000;
    end
    us = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 200000));
    send(l, r, ($urandom_range(9) != 0), us);
  endtask

  initial begin
    int p;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          tx_idle = 9;  rx_idle = 71;
          write_reg(CFG_MPT, MPT_RESET);
          write_reg(CFG_IWB, IWB_RESET);
          write_reg(2'd2, 32'hDEAD_BEEF);   // unused index, ignored
          write_reg(2'd3, 32'h1234_5678);
        end
        1: begin
          tx_idle = 71; rx_idle = 9;
          write_reg(CFG_MPT, 32'hFFFF_FFFF);
          write_reg(CFG_IWB, 32'hFFFF_FFFF);
        end
        2: begin
          tx_idle = 0;  rx_idle = 0;
          write_reg(CFG_MPT, 32'd1);
          write_reg(CFG_IWB, 32'd1);
        end
        default: begin
          tx_idle = 0;  rx_idle = 0;
          write_reg(CFG_MPT, $urandom_range(1, 32'hFFFF_FFFF));
          write_reg(CFG_IWB, $urandom_range(1, 32'hFFFF_FFFF));
        end
      endcase

      if (p == 0 || p == 1) begin
        // first sample (from the reset counts in the first pass), then extremes
        send(32'sd100, 32'sd300, 1'b1, 24'd100000);
        send(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 24'd1);
        send(-32'sh8000_0000, -32'sh8000_0000, 1'b1, 24'hFF_FFFF);  // rollover
        send(32'sh7FFF_FFFF, -32'sh8000_0000, 1'b1, 24'd1000);     // many turns
        send(-32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 24'd1000);
        send(32'sd0, 32'sd0, 1'b0, 24'd50000);                     // stale counts
        send(32'sd0, 32'sd0, 1'b1, 24'd0);                         // zero elapsed
        send(32'sd5000, 32'sd5000, 1'b1, 24'd0);
        send(32'sd5000, 32'sd4000, 1'b1, 24'h80_0000);
        send(32'sd6000, 32'sd9000, 1'b1, 24'h7F_FFFF);
        send(32'sh5555_5555, 32'shAAAA_AAAA, 1'b1, 24'h55_5555);
        send(32'shAAAA_AAAA, 32'sh5555_5555, 1'b1, 24'hAA_AAAA);
        send(32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, 24'hFF_FFFF);
        send(32'sd0, 32'sd0, 1'b1, 24'd1);
        send(32'sd1, -32'sd1, 1'b1, 24'd1);
        send(-32'sd1, 32'sd1, 1'b1, 24'd1);
      end

      for (int i = 0; i < 100; i++) begin
        if (p == 1 && i == 50) begin
          // sender pause until the pipeline is empty
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending_count != 0) @(posedge clk);
        end
        if (p == 2 && i == 10) hold_cycles <= 3000;
        send_random();
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl
rtl/ddo_pkg.sv
rtl/ddo_ifs.sv
rtl/ddo_mul.sv
rtl/ddo_div.sv
rtl/differential_drive_odometry_top.sv
rtl/ddo_sva.sv
dv/ddo_odometry_checker.sv
dv/tb_differential_drive_odometry_top.sv
